// File: sv/jpr_pkg.sv
// Shared types and constants for the joypad packet receiver.
`default_nettype none
package jpr_pkg;

  // Packet and command store geometry.
  localparam int PacketBits = 128;
  localparam int CmdRows    = 7;
  localparam int LogoRows   = 4;
  localparam int RowBytes   = 16;

  // Receiver codes.
  localparam logic [7:0] IdlePos       = 8'hFF;
  localparam logic [7:0] FullPos       = 8'd128;
  localparam logic [7:0] HeaderCode    = 8'hF1;
  localparam logic [2:0] HeaderPackets = 3'd6;
  localparam logic [2:0] NoRoomSlot    = 3'd7;
  localparam logic [4:0] SingleCodeMin = 5'h1E;

  // Select line codes.
  localparam logic [1:0] SelBothLow  = 2'b00;
  localparam logic [1:0] SelLowOnly  = 2'b01;
  localparam logic [1:0] SelBothHigh = 2'b11;

  // Header flag check: two bytes of the command store and their expected values.
  localparam int         CheckAAddr = 'h4C;
  localparam int         CheckBAddr = 'h53;
  localparam int         CheckARow  = CheckAAddr / RowBytes;
  localparam int         CheckALsb  = (CheckAAddr % RowBytes) * 8;
  localparam int         CheckBRow  = CheckBAddr / RowBytes;
  localparam int         CheckBLsb  = (CheckBAddr % RowBytes) * 8;
  localparam logic [7:0] CheckAValue = 8'h03;
  localparam logic [7:0] CheckBValue = 8'h33;

  // Read map boundaries.
  localparam logic [10:0] MapCmdEnd   = 11'd112;
  localparam logic [10:0] MapLogoBase = 11'd128;
  localparam logic [10:0] MapLogoEnd  = 11'd176;
  localparam logic [10:0] MapConstAddr = 11'd1537;
  localparam logic [7:0]  MapConstValue = 8'h03;
  localparam logic [5:0]  LogoSpan    = 6'd14;

  // Configuration register indexes.
  typedef enum logic {
    RegPlayerMask = 1'b0,
    RegUnused     = 1'b1
  } jpr_reg_e;

  // Command store write request from the receiver.
  typedef struct packed {
    logic       wr_en;
    logic [2:0] wr_row;
    logic       logo_load;
  } jpr_commit_t;

  // Per-step outcome of the receiver.
  typedef struct packed {
    logic       ready;
    logic [4:0] code;
    logic [2:0] packets;
    logic       disabled;
    logic       header;
  } jpr_status_t;

endpackage
`default_nettype wire

// File: sv/jpr_store.sv
// Command store rows, latched logo bytes and the read map.
`default_nettype none
module jpr_store (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire jpr_pkg::jpr_commit_t  commit_i,
  input  wire logic [127:0]          packet_i,
  input  wire logic                  logo_valid_i,
  input  wire logic [10:0]           rd_offset_i,
  output logic [7:0]                 rd_data_o,
  output logic [7:0]                 cmd0_o,
  output logic [7:0]                 chk_a_o,
  output logic [7:0]                 chk_b_o
);
  import jpr_pkg::*;

  logic [PacketBits-1:0] rows_q [0:CmdRows-1];
  logic [CmdRows-1:0]    row_valid_q;
  logic [111:0]          logo_q [0:LogoRows-1];
  logic [PacketBits-1:0] eff_row [0:LogoRows-1];
  logic [2:0]            cmd_row;
  logic [1:0]            logo_row;
  logic [5:0]            logo_idx;
  logic [5:0]            logo_byte;

  // A row that was never written reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
    end else if (commit_i.wr_en) begin
      row_valid_q[commit_i.wr_row] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit_i.wr_en) begin
      rows_q[commit_i.wr_row] <= packet_i;
    end
  end

  // Rows as they stand after this commit, for the logo copy.
  always_comb begin
    for (int r = 0; r < LogoRows; r++) begin
      if (commit_i.wr_en && commit_i.wr_row == 3'(r)) begin
        eff_row[r] = packet_i;
      end else if (row_valid_q[r]) begin
        eff_row[r] = rows_q[r];
      end else begin
        eff_row[r] = '0;
      end
    end
  end

  // The logo takes bytes 2 to 15 of the first four rows.
  always_ff @(posedge clk_i) begin
    if (commit_i.logo_load) begin
      for (int r = 0; r < LogoRows; r++) begin
        logo_q[r] <= eff_row[r][PacketBits-1:16];
      end
    end
  end

  // Fixed bytes used by the commit logic.
  assign cmd0_o  = row_valid_q[0] ? rows_q[0][7:0] : 8'd0;
  assign chk_a_o = row_valid_q[CheckARow] ? rows_q[CheckARow][CheckALsb +: 8] : 8'd0;
  assign chk_b_o = row_valid_q[CheckBRow] ? rows_q[CheckBRow][CheckBLsb +: 8] : 8'd0;

  // Logo position: fourteen bytes per source row.
  assign cmd_row  = rd_offset_i[6:4];
  assign logo_idx = rd_offset_i[5:0];
  always_comb begin
    if (logo_idx < LogoSpan) begin
      logo_row  = 2'd0;
      logo_byte = logo_idx;
    end else if (logo_idx < 6'(2 * LogoSpan)) begin
      logo_row  = 2'd1;
      logo_byte = logo_idx - LogoSpan;
    end else if (logo_idx < 6'(3 * LogoSpan)) begin
      logo_row  = 2'd2;
      logo_byte = logo_idx - 6'(2 * LogoSpan);
    end else begin
      logo_row  = 2'd3;
      logo_byte = logo_idx - 6'(3 * LogoSpan);
    end
  end

  // Read map decode.
  always_comb begin
    rd_data_o = 8'd0;
    if (rd_offset_i < MapCmdEnd) begin
      if (row_valid_q[cmd_row]) begin
        rd_data_o = rows_q[cmd_row][rd_offset_i[3:0]*8 +: 8];
      end
    end else if (rd_offset_i >= MapLogoBase && rd_offset_i < MapLogoEnd) begin
      if (logo_valid_i) begin
        rd_data_o = logo_q[logo_row][logo_byte[3:0]*8 +: 8];
      end
    end else if (rd_offset_i == MapConstAddr) begin
      rd_data_o = MapConstValue;
    end
  end

endmodule
`default_nettype wire

// File: sv/jpr_rx.sv
// Bit-serial packet shifter and command commit control.
`default_nettype none
module jpr_rx (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  wr_en_i,
  input  wire logic [1:0]            old_sel_i,
  input  wire logic [1:0]            new_sel_i,
  input  wire logic [7:0]            cmd0_i,
  input  wire logic [7:0]            chk_a_i,
  input  wire logic [7:0]            chk_b_i,
  output jpr_pkg::jpr_commit_t       commit_o,
  output logic [127:0]               packet_o,
  output logic                       header_o,
  output jpr_pkg::jpr_status_t       status_o
);
  import jpr_pkg::*;

  logic [7:0]            pos_q, pos_d;
  logic [PacketBits-1:0] packet_q, packet_d;
  logic [2:0]            slot_q, slot_d;
  logic                  header_q, header_d;
  logic                  disable_q, disable_d;
  logic [2:0]            slot_inc;
  logic [7:0]            eff0, eff_a, eff_b;
  logic [2:0]            cmd_len;

  assign slot_inc = slot_q + 3'd1;

  // Bytes as they stand once the current packet is committed.
  assign eff0  = (slot_q == 3'd0) ? packet_q[7:0] : cmd0_i;
  assign eff_a = (slot_q == 3'(CheckARow)) ? packet_q[CheckALsb +: 8] : chk_a_i;
  assign eff_b = (slot_q == 3'(CheckBRow)) ? packet_q[CheckBLsb +: 8] : chk_b_i;
  assign cmd_len = (eff0[2:0] == 3'd0) ? 3'd1 : eff0[2:0];

  // Next-state logic for one select write.
  always_comb begin
    pos_d     = pos_q;
    packet_d  = packet_q;
    slot_d    = slot_q;
    header_d  = header_q;
    disable_d = disable_q;
    commit_o  = '0;
    status_o  = '0;
    if (wr_en_i && !disable_q) begin
      if (new_sel_i == SelBothLow) begin
        packet_d = '0;
        pos_d    = IdlePos;
      end else if (new_sel_i == SelBothHigh) begin
        if (pos_q == IdlePos) begin
          if (old_sel_i == SelBothLow) begin
            pos_d = 8'd0;
          end
        end else if (pos_q < FullPos) begin
          if (old_sel_i == SelLowOnly) begin
            packet_d[pos_q[6:0]] = 1'b1;
          end
          pos_d = pos_q + 8'd1;
        end else begin
          // Commit the packet into the command store.
          pos_d           = IdlePos;
          commit_o.wr_en  = (slot_q != NoRoomSlot);
          commit_o.wr_row = slot_q;
          if (header_q) begin
            slot_d = slot_inc;
            if (slot_inc == cmd_len) begin
              status_o.ready   = 1'b1;
              status_o.code    = eff0[7:3];
              status_o.packets = cmd_len;
              slot_d           = 3'd0;
            end
            if (eff0[7:3] >= SingleCodeMin) begin
              slot_d = 3'd0;
            end
          end else if (eff0 != HeaderCode) begin
            slot_d = 3'd0;
          end else begin
            slot_d = slot_inc;
            if (slot_inc == HeaderPackets) begin
              commit_o.logo_load = 1'b1;
              if (eff_a != CheckAValue || eff_b != CheckBValue) begin
                disable_d = 1'b1;
              end
              header_d = 1'b1;
              slot_d   = 3'd0;
            end
          end
        end
      end
    end
    status_o.disabled = disable_d;
    status_o.header   = header_d;
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= IdlePos;
      slot_q    <= 3'd0;
      header_q  <= 1'b0;
      disable_q <= 1'b0;
      packet_q  <= '0;
    end else begin
      pos_q     <= pos_d;
      slot_q    <= slot_d;
      header_q  <= header_d;
      disable_q <= disable_d;
      packet_q  <= packet_d;
    end
  end

  assign packet_o = packet_q;
  assign header_o = header_q;

endmodule
`default_nettype wire

// File: sv/joypad_packet_receiver_core.sv
// Top level of the joypad packet receiver: handshake, configuration and result stage.
// Each transaction on the input channel is either a joypad select write or a read of the
// command buffer map, and gives exactly one result transaction. One transaction is accepted
// per cycle while in_stall_o is low; each result passes through the input register, then the
// single update stage that writes the receiver state and the result register together. While
// a result waits under stall, the input register takes one more transaction and then stalls
// the input channel. The command store
// clears through per-row valid bits at reset, so no clearing pass is needed. The APB port
// holds player_mask at byte address 0; write it only while the block is idle.
`default_nettype none
module joypad_packet_receiver_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input channel.
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        func_i,
  input  wire logic [1:0]  select_lines_i,
  input  wire logic [10:0] read_offset_i,
  // Result channel.
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             command_ready_o,
  output logic [4:0]       command_code_o,
  output logic [2:0]       command_packets_o,
  output logic [7:0]       read_data_o,
  output logic             reception_disabled_o,
  output logic             header_received_o,
  output logic [1:0]       player_number_o,
  // Configuration port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import jpr_pkg::*;

  logic        in_valid_q;
  logic        func_q;
  logic [1:0]  sel_q;
  logic [10:0] offset_q;
  logic        out_valid_q;
  logic        can_adv, fire, wr_step, in_take;
  logic [1:0]  prev_sel_q;
  logic [1:0]  player_q, player_d;
  logic [1:0]  player_mask_q;
  jpr_reg_e    reg_idx;

  jpr_commit_t commit;
  jpr_status_t status;
  logic [127:0] packet;
  logic         header;
  logic [7:0]   rd_data, cmd0, chk_a, chk_b;

  // Handshake: the input register advances whenever the result register can take data.
  assign can_adv    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && can_adv;
  assign in_stall_o = in_valid_q && !can_adv;
  assign in_take    = in_valid_i && !in_stall_o;
  assign wr_step    = fire && !func_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Input payload register.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      func_q   <= func_i;
      sel_q    <= select_lines_i;
      offset_q <= read_offset_i;
    end
  end

  // Configuration register.
  assign reg_idx = jpr_reg_e'(paddr[2]);
  assign pready  = 1'b1;
  assign prdata  = (reg_idx == RegPlayerMask) ? {30'd0, player_mask_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      player_mask_q <= 2'd0;
    end else if (psel && penable && pwrite && pready && reg_idx == RegPlayerMask) begin
      player_mask_q <= pwdata[1:0];
    end
  end

  // Player index advances on a rising edge of select bit 1.
  always_comb begin
    player_d = player_q;
    if (!prev_sel_q[1] && sel_q[1]) begin
      player_d = (player_q + 2'd1) & player_mask_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_sel_q <= SelBothHigh;
      player_q   <= 2'd0;
    end else if (wr_step) begin
      prev_sel_q <= sel_q;
      player_q   <= player_d;
    end
  end

  jpr_rx u_rx (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_step),
    .old_sel_i (prev_sel_q),
    .new_sel_i (sel_q),
    .cmd0_i    (cmd0),
    .chk_a_i   (chk_a),
    .chk_b_i   (chk_b),
    .commit_o  (commit),
    .packet_o  (packet),
    .header_o  (header),
    .status_o  (status)
  );

  jpr_store u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .commit_i     (commit),
    .packet_i     (packet),
    .logo_valid_i (header),
    .rd_offset_i  (offset_q),
    .rd_data_o    (rd_data),
    .cmd0_o       (cmd0),
    .chk_a_o      (chk_a),
    .chk_b_o      (chk_b)
  );

  // Result register.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      command_ready_o      <= status.ready;
      command_code_o       <= status.code;
      command_packets_o    <= status.packets;
      read_data_o          <= func_q ? rd_data : 8'd0;
      reception_disabled_o <= status.disabled;
      header_received_o    <= status.header;
      player_number_o      <= func_q ? player_q : player_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// File: bench/joypad_packet_receiver_core_tb.sv
// Self-checking testbench for the joypad packet receiver core.
module joypad_packet_receiver_core_tb;
  import jpr_pkg::*;

  // Transaction kinds on the input channel and the select code not in the package.
  localparam logic       FuncSelect  = 1'b0;
  localparam logic       FuncRead    = 1'b1;
  localparam logic [1:0] SelHighOnly = 2'b10;
  localparam int         LogoBytes   = 48;
  localparam int         MaxWait     = 14;
  localparam int         ChunkItems  = 100;

  // One result transaction as the receiver reports it.
  typedef struct packed {
    logic       ready;
    logic [4:0] code;
    logic [2:0] packets;
    logic [7:0] data;
    logic       disabled;
    logic       header;
    logic [1:0] player;
  } reply_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_stall;
  logic        func;
  logic [1:0]  select_lines;
  logic [10:0] read_offset;
  logic        out_valid;
  logic        out_stall;
  logic        command_ready;
  logic [4:0]  command_code;
  logic [2:0]  command_packets;
  logic [7:0]  read_data;
  logic        reception_disabled;
  logic        header_received;
  logic [1:0]  player_number;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  joypad_packet_receiver_core dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .func_i              (func),
    .select_lines_i      (select_lines),
    .read_offset_i       (read_offset),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .command_ready_o     (command_ready),
    .command_code_o      (command_code),
    .command_packets_o   (command_packets),
    .read_data_o         (read_data),
    .reception_disabled_o(reception_disabled),
    .header_received_o   (header_received),
    .player_number_o     (player_number),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  // Receiver state as the testbench predicts it.
  logic [1:0]   last_sel;
  logic [7:0]   bit_pos;
  logic [127:0] shift_reg;
  logic [7:0]   cmd_mem [CmdRows*RowBytes];
  logic [2:0]   slot;
  logic [7:0]   logo [LogoBytes];
  logic         hdr_seen;
  logic         rx_off;
  logic [1:0]   player;
  logic [1:0]   mask;

  reply_t replies_due [$];
  int     mismatches = 0;
  int     items_sent = 0;
  int     stall_left = 0;
  bit     steady = 1'b0;

  // Clock with a period of 8.
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  function automatic void model_reset();
    last_sel  = SelBothHigh;
    bit_pos   = IdlePos;
    shift_reg = '0;
    slot      = '0;
    hdr_seen  = 1'b0;
    rx_off    = 1'b0;
    player    = '0;
    mask      = '0;
    foreach (cmd_mem[k]) cmd_mem[k] = '0;
    foreach (logo[k]) logo[k] = '0;
  endfunction

  // Byte seen at one offset of the read map.
  function automatic logic [7:0] map_byte(input logic [10:0] off);
    if (off < MapCmdEnd) return cmd_mem[off];
    if (off < MapLogoBase) return '0;
    if (off < MapLogoEnd) return logo[off - MapLogoBase];
    if (off == MapConstAddr) return MapConstValue;
    return '0;
  endfunction

  // Applies one input transaction to the predicted state and returns its result.
  function automatic reply_t receiver_step(input logic fn, input logic [1:0] sel,
                                           input logic [10:0] off);
    reply_t     r;
    logic [1:0] old_sel;
    logic [2:0] need;
    r = '0;
    old_sel = last_sel;
    if (fn == FuncRead) begin
      r.data = map_byte(off);
    end else begin
      if (!rx_off) begin
        if (sel == SelBothLow) begin
          shift_reg = '0;
          bit_pos = IdlePos;
        end else if (sel == SelBothHigh) begin
          if (bit_pos == IdlePos) begin
            if (old_sel == SelBothLow) bit_pos = '0;
          end else if (bit_pos < FullPos) begin
            shift_reg[bit_pos[6:0]] = shift_reg[bit_pos[6:0]] | (old_sel == SelLowOnly);
            bit_pos = bit_pos + 8'd1;
          end else begin
            // Full packet: store it, then run the header or command bookkeeping.
            bit_pos = IdlePos;
            if (slot != NoRoomSlot) begin
              for (int k = 0; k < RowBytes; k++) cmd_mem[slot*RowBytes + k] = shift_reg[8*k +: 8];
            end
            if (hdr_seen) begin
              need = (cmd_mem[0][2:0] == 3'd0) ? 3'd1 : cmd_mem[0][2:0];
              slot = slot + 3'd1;
              if (slot == need) begin
                r.ready = 1'b1;
                r.code = cmd_mem[0][7:3];
                r.packets = need;
                slot = '0;
              end
              if (cmd_mem[0][7:3] >= SingleCodeMin) slot = '0;
            end else if (cmd_mem[0] != HeaderCode) begin
              slot = '0;
            end else begin
              slot = slot + 3'd1;
              if (slot == HeaderPackets) begin
                for (int k = 0; k < LogoBytes; k++) begin
                  logo[k] = cmd_mem[(k / LogoSpan) * RowBytes + 2 + (k % LogoSpan)];
                end
                if (cmd_mem[CheckAAddr] != CheckAValue || cmd_mem[CheckBAddr] != CheckBValue) begin
                  rx_off = 1'b1;
                end
                hdr_seen = 1'b1;
                slot = '0;
              end
            end
          end
        end
      end
      if (!old_sel[1] && sel[1]) player = (player + 2'd1) & mask;
      last_sel = sel;
    end
    r.disabled = rx_off;
    r.header = hdr_seen;
    r.player = player;
    return r;
  endfunction

  function automatic int draw_wait();
    return steady ? 0 : $urandom_range(0, MaxWait);
  endfunction

  function automatic string show_reply(input reply_t r);
    return $sformatf("ready=%0d code=%0d packets=%0d data=%0d disabled=%0d header=%0d player=%0d",
                     r.ready, r.code, r.packets, r.data, r.disabled, r.header, r.player);
  endfunction

  // Result stall: a random hold before each result transaction.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each result transaction with the oldest prediction.
  always @(posedge clk_i) begin
    reply_t got;
    reply_t want;
    if (rst_ni && out_valid && !out_stall) begin
      got = '{command_ready, command_code, command_packets, read_data,
              reception_disabled, header_received, player_number};
      if (replies_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %s", show_reply(got));
      end else begin
        want = replies_due.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected %s", show_reply(want));
            $display("          actual   %s", show_reply(got));
          end
        end
      end
      stall_left = draw_wait();
    end
  end

  // Send one input transaction and record its predicted result on acceptance.
  task automatic send_item(input logic fn, input logic [1:0] sel, input logic [10:0] off);
    int gap;
    gap = draw_wait();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    func <= fn;
    select_lines <= sel;
    read_offset <= off;
    do @(posedge clk_i); while (in_stall);
    replies_due.push_back(receiver_step(fn, sel, off));
    items_sent++;
  endtask

  function automatic logic [10:0] rand_offset();
    case ($urandom_range(0, 7))
      0: return 11'($urandom_range(0, 2047));
      1: return 11'($urandom_range(1535, 1538));
      default: return 11'($urandom_range(0, 175));
    endcase
  endfunction

  function automatic logic [127:0] random_row();
    logic [127:0] v;
    v = {$urandom, $urandom, $urandom, $urandom};
    if ($urandom_range(0, 2) == 0) v &= {$urandom, $urandom, $urandom, $urandom};
    return v;
  endfunction

  task automatic write_sel(input logic [1:0] sel);
    send_item(FuncSelect, sel, 11'($urandom_range(0, 2047)));
  endtask

  task automatic read_map(input logic [10:0] off);
    send_item(FuncRead, 2'($urandom_range(0, 3)), off);
  endtask

  // Shift one 128-bit packet in LSB first, with varied encodings for each bit.
  task automatic shift_packet(input logic [127:0] bits);
    write_sel(SelBothLow);
    write_sel(SelBothHigh);
    for (int i = 0; i < PacketBits; i++) begin
      if ($urandom_range(0, 63) == 0) read_map(rand_offset());
      if (bits[i]) begin
        if ($urandom_range(0, 7) == 0) write_sel(SelHighOnly);
        write_sel(SelLowOnly);
      end else begin
        case ($urandom_range(0, 7))
          0: write_sel(SelHighOnly);
          1: begin
            write_sel(SelLowOnly);
            write_sel(SelHighOnly);
          end
          default: ;
        endcase
      end
      write_sel(SelBothHigh);
    end
    write_sel(SelBothHigh);
  endtask

  // Wait until every predicted result has arrived and the pipeline is empty.
  task automatic drain_results();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // APB write of player_mask, with random upper data bits.
  task automatic set_player_mask(input logic [1:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(4 * RegPlayerMask);
    pwdata <= {30'($urandom), value};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    mask = value;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Reads at every boundary of the map, with the ignored select field at both extremes.
  task automatic test_map_reads();
    send_item(FuncRead, SelBothLow, 11'd0);
    send_item(FuncRead, SelBothHigh, 11'd111);
    send_item(FuncRead, SelBothLow, 11'd112);
    send_item(FuncRead, SelBothHigh, 11'd127);
    send_item(FuncRead, SelLowOnly, 11'd128);
    send_item(FuncRead, SelHighOnly, 11'd175);
    send_item(FuncRead, SelBothLow, 11'd176);
    send_item(FuncRead, SelBothHigh, 11'd1535);
    send_item(FuncRead, SelBothHigh, 11'd1536);
    send_item(FuncRead, SelBothLow, 11'd1537);
    send_item(FuncRead, SelBothHigh, 11'd1538);
    send_item(FuncRead, SelBothLow, 11'd2047);
  endtask

  // Select writes: half-high codes, idle highs, a start and an abort, player edges.
  task automatic test_select_edges();
    send_item(FuncSelect, SelLowOnly, 11'd2047);
    send_item(FuncSelect, SelBothHigh, 11'd0);
    send_item(FuncSelect, SelHighOnly, 11'd2047);
    send_item(FuncSelect, SelBothLow, 11'd0);
    send_item(FuncSelect, SelBothHigh, 11'd1234);
    send_item(FuncSelect, SelLowOnly, 11'd0);
    send_item(FuncSelect, SelBothHigh, 11'd2047);
    send_item(FuncSelect, SelBothLow, 11'd2047);
    send_item(FuncSelect, SelHighOnly, 11'd0);
    send_item(FuncSelect, SelBothHigh, 11'd0);
  endtask

  // A stray packet, an aborted packet, then the six-packet header.
  task automatic test_header_entry();
    logic [127:0] bits;
    int           verdict;
    verdict = $urandom_range(0, 11);
    bits = random_row();
    if (bits[7:0] == HeaderCode) bits[7:0] = 8'h00;
    shift_packet(bits);
    write_sel(SelBothLow);
    write_sel(SelBothHigh);
    repeat (5) write_sel(SelBothHigh);
    write_sel(SelBothLow);
    for (int p = 0; p < HeaderPackets; p++) begin
      bits = random_row();
      if (p == 0) bits[7:0] = HeaderCode;
      if (p == CheckARow) bits[CheckALsb +: 8] = (verdict == 0) ? ~CheckAValue : CheckAValue;
      if (p == CheckBRow) bits[CheckBLsb +: 8] = (verdict == 1) ? ~CheckBValue : CheckBValue;
      shift_packet(bits);
    end
  endtask

  // One command: first packet carries code and length, the rest random content.
  task automatic send_command();
    logic [127:0] bits;
    logic [4:0]   code;
    logic [2:0]   len;
    int           count;
    code = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(int'(SingleCodeMin), 31))
                                       : 5'($urandom_range(0, 31));
    len = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(0, 2));
    count = (len == 3'd0) ? 1 : int'(len);
    for (int p = 0; p < count; p++) begin
      bits = random_row();
      if (p == 0) bits[7:0] = {code, len};
      shift_packet(bits);
    end
  endtask

  // Mostly well-formed commands, with reads, select noise and aborted packets between.
  task automatic test_command_stream();
    int target;
    int pick;
    for (int m = 0; m < 4; m++) begin
      drain_results();
      set_player_mask(2'(m ^ 1));
      target = items_sent + ChunkItems;
      while (items_sent < target) begin
        steady = ($urandom_range(0, 7) == 0);
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          send_command();
        end else if (pick == 7) begin
          repeat ($urandom_range(1, 4)) read_map(rand_offset());
        end else if (pick == 8) begin
          repeat ($urandom_range(1, 6)) write_sel(2'($urandom_range(0, 3)));
        end else begin
          write_sel(SelBothLow);
          write_sel(SelBothHigh);
          repeat ($urandom_range(1, 40)) write_sel(2'($urandom_range(1, 3)));
          write_sel(SelBothLow);
        end
      end
    end
    steady = 1'b0;
  endtask

  // Main sequence.
  initial begin
    rst_ni = 1'b0;
    in_valid = 1'b0;
    func = FuncSelect;
    select_lines = SelBothHigh;
    read_offset = '0;
    out_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    model_reset();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    set_player_mask(2'd3);
    test_map_reads();
    test_select_edges();
    test_header_entry();
    test_command_stream();
    drain_results();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && replies_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
